/* src/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// shared types and constants of the line follower pd steering block
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int FRAC_BITS    = 8;
  localparam int GAIN_FRAC    = 8;

  localparam int SPEED_W    = 9;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 10;
  localparam int DRIVE_W    = 11;
  localparam int MODE_W     = 2;
  localparam int HOLD_W     = 7;
  localparam int OFFSET_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int WEIGHT_W  = 5;
  localparam int SUM_W     = 7;
  localparam int SUM_MAG_W = SUM_W - 1;
  localparam int COUNT_W   = $clog2(SENSOR_COUNT + 1);
  localparam int DIV_W     = SUM_MAG_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [WEIGHT_W-1:0] WEIGHTS [SENSOR_COUNT] = '{
    -5'sd15, -5'sd6, -5'sd2, 5'sd0, 5'sd0, 5'sd2, 5'sd6, 5'sd15
  };

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST   = 9'd200;
  localparam logic [SPEED_W-1:0] SEARCH_SPEED_RST = 9'd100;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd3072;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd5120;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST  = 10'd500;

  localparam logic signed [DRIVE_W-1:0] PIVOT_L_LEFT  = -11'sd150;
  localparam logic signed [DRIVE_W-1:0] PIVOT_L_RIGHT = 11'sd300;
  localparam logic signed [DRIVE_W-1:0] PIVOT_R_LEFT  = 11'sd400;
  localparam logic signed [DRIVE_W-1:0] PIVOT_R_RIGHT = -11'sd250;

  localparam logic [HOLD_W-1:0] HOLD_TRACK   = 7'd10;
  localparam logic [HOLD_W-1:0] HOLD_PIVOT_L = 7'd30;
  localparam logic [HOLD_W-1:0] HOLD_PIVOT_R = 7'd90;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRACK   = 2'd0,
    MODE_PIVOT_L = 2'd1,
    MODE_PIVOT_R = 2'd2,
    MODE_LOST    = 2'd3
  } steer_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED   = 3'd0,
    CFG_SEARCH_SPEED = 3'd1,
    CFG_PROP_GAIN    = 3'd2,
    CFG_DERIV_GAIN   = 3'd3,
    CFG_DRIVE_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_prop;
    logic mul_deriv;
    logic corr;
    logic drive;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_track;
    logic div_done;
  } dp_status_t;

endpackage

/* src/line_follow_pd_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// weighted centroid line follower with pd differential steering
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   config  | cfg_we_i, cfg_idx_i, cfg_wdata_i           | in
//   sample  | in_valid_i, in_ready_o, sensor_bits_i      | in
//   command | out_valid_o, out_ready_i, left_drive_o,    | out
//           | right_drive_o, steer_mode_o, hold_ms_o,    |
//           | line_pos_o                                 |
//
// a tracking sample goes from its transfer to the next possible
// transfer: 14 steps of the restoring centroid divider, two passes of the
// shared gain multiplier, then correction, clamp and result load
// pivot and line-lost samples go straight from transfer to result load
// reset restores the default registers and clears the previous offset
// a held result stalls the result load, and no new sample is taken meanwhile
// ----------------------------------------------------------------------------
module line_follow_pd_steering (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [lfpd_pkg::SENSOR_COUNT-1:0]     sensor_bits_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]   left_drive_o,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]   right_drive_o,
  output logic [lfpd_pkg::MODE_W-1:0]           steer_mode_o,
  output logic [lfpd_pkg::HOLD_W-1:0]           hold_ms_o,
  output logic signed [lfpd_pkg::OFFSET_W-1:0]  line_pos_o
);
  import lfpd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lfpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfpd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sensor_bits_i (sensor_bits_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .steer_mode_o  (steer_mode_o),
    .hold_ms_o     (hold_ms_o),
    .line_pos_o    (line_pos_o)
  );

endmodule

/* src/lfpd_ctrl.sv */
// ----------------------------------------------------------------------------
// lfpd_ctrl
// sequencer of the steering datapath and owner of both handshakes
// ----------------------------------------------------------------------------
module lfpd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lfpd_pkg::dp_status_t status_i,
  output lfpd_pkg::dp_cmd_t    cmd_o
);
  import lfpd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_MULP  = 7'b0000100,
    ST_MULD  = 7'b0001000,
    ST_CORR  = 7'b0010000,
    ST_DRIVE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          state_d = status_i.in_track ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_MULP;
        end
      end
      ST_MULP: begin
        cmd_o.mul_prop = 1'b1;
        state_d        = ST_MULD;
      end
      ST_MULD: begin
        cmd_o.mul_deriv = 1'b1;
        state_d         = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd_o.drive = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.out_load = slot_free;
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/lfpd_dp.sv */
// ----------------------------------------------------------------------------
// lfpd_dp
// config registers, centroid divider, shared gain multiplier, drive clamp
// and result register
// ----------------------------------------------------------------------------
module lfpd_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic [lfpd_pkg::SENSOR_COUNT-1:0]        sensor_bits_i,
  input  lfpd_pkg::dp_cmd_t                        cmd_i,
  output lfpd_pkg::dp_status_t                     status_o,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]      left_drive_o,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]      right_drive_o,
  output logic [lfpd_pkg::MODE_W-1:0]              steer_mode_o,
  output logic [lfpd_pkg::HOLD_W-1:0]              hold_ms_o,
  output logic signed [lfpd_pkg::OFFSET_W-1:0]     line_pos_o
);
  import lfpd_pkg::*;

  localparam int MUL_A_W = OFFSET_W + 1;
  localparam int PROD_W  = MUL_A_W + GAIN_W + 1;
  localparam int PD_W    = PROD_W + 1;
  localparam int SHIFT   = FRAC_BITS + GAIN_FRAC;
  localparam int CORR_W  = PD_W - SHIFT;
  localparam int SUMD_W  = CORR_W + 1;
  localparam int REM_W   = COUNT_W + 1;

  localparam logic signed [PD_W-1:0] RND_BIAS = $signed({{(PD_W-SHIFT){1'b0}}, {SHIFT{1'b1}}});

  // config registers
  logic [SPEED_W-1:0] base_q, search_q;
  logic [GAIN_W-1:0]  prop_q, deriv_q;
  logic [LIMIT_W-1:0] limit_q;

  // item state
  steer_mode_e                mode_q;
  logic                       neg_q;
  logic [DIV_W-1:0]           dq_q;
  logic [REM_W-1:0]           rem_q;
  logic [COUNT_W-1:0]         divisor_q;
  logic [DIV_CNT_W-1:0]       cnt_q;
  logic signed [OFFSET_W-1:0] offset_q, prev_q;
  logic signed [PROD_W-1:0]   prod_p_q, prod_d_q;
  logic signed [CORR_W-1:0]   corr_q;
  logic signed [DRIVE_W-1:0]  left_q, right_q;

  // input decode
  logic signed [SUM_W-1:0]   sum_c;
  logic [COUNT_W-1:0]        count_c;
  logic [SUM_MAG_W-1:0]      mag_c;
  steer_mode_e               mode_c;

  always_comb begin
    sum_c   = '0;
    count_c = '0;
    for (int i = 1; i < SENSOR_COUNT - 1; i++) begin
      if (sensor_bits_i[i]) begin
        sum_c   = sum_c + SUM_W'(WEIGHTS[i]);
        count_c = count_c + COUNT_W'(1);
      end
    end
    mag_c = sum_c[SUM_W-1] ? SUM_MAG_W'(-sum_c) : sum_c[SUM_MAG_W-1:0];
    priority if (sensor_bits_i[0]) begin
      mode_c = MODE_PIVOT_L;
    end else if (sensor_bits_i[SENSOR_COUNT-1]) begin
      mode_c = MODE_PIVOT_R;
    end else if (count_c == '0) begin
      mode_c = MODE_LOST;
    end else begin
      mode_c = MODE_TRACK;
    end
  end

  assign status_o.in_track = (mode_c == MODE_TRACK);
  assign status_o.div_done = (cnt_q == '0);

  // restoring divider step
  logic [REM_W-1:0] trial_c;
  logic             qbit_c;
  logic [REM_W-1:0] rem_c;

  always_comb begin
    trial_c = {rem_q[REM_W-2:0], dq_q[DIV_W-1]};
    qbit_c  = (trial_c >= {1'b0, divisor_q});
    rem_c   = qbit_c ? (trial_c - {1'b0, divisor_q}) : trial_c;
  end

  // shared multiplier
  logic signed [OFFSET_W-1:0] quot_c, offset_c;
  logic signed [MUL_A_W-1:0]  diff_c, mul_a;
  logic signed [GAIN_W:0]     mul_b;
  logic signed [PROD_W-1:0]   prod_c;

  always_comb begin
    quot_c   = $signed(dq_q[OFFSET_W-1:0]);
    offset_c = neg_q ? -quot_c : quot_c;
    diff_c   = MUL_A_W'(offset_q) - MUL_A_W'(prev_q);
    mul_a    = cmd_i.mul_prop ? MUL_A_W'(offset_c) : diff_c;
    mul_b    = $signed({1'b0, cmd_i.mul_prop ? prop_q : deriv_q});
    prod_c   = mul_a * mul_b;
  end

  // correction, truncated toward zero
  logic signed [PD_W-1:0]   pd_c, pd_adj_c;
  logic signed [CORR_W-1:0] corr_c;

  always_comb begin
    pd_c     = PD_W'(prod_p_q) + PD_W'(prod_d_q);
    pd_adj_c = pd_c[PD_W-1] ? (pd_c + RND_BIAS) : pd_c;
    corr_c   = CORR_W'(pd_adj_c >>> SHIFT);
  end

  // drives with symmetric clamp
  logic signed [SUMD_W-1:0] base_s, lim_s, lsum_c, rsum_c;

  function automatic logic signed [SUMD_W-1:0] clamp_drive(
    input logic signed [SUMD_W-1:0] v,
    input logic signed [SUMD_W-1:0] lim
  );
    logic signed [SUMD_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    base_s = $signed({{(SUMD_W-SPEED_W){1'b0}}, base_q});
    lim_s  = $signed({{(SUMD_W-LIMIT_W){1'b0}}, limit_q});
    lsum_c = clamp_drive(base_s + SUMD_W'(corr_q), lim_s);
    rsum_c = clamp_drive(base_s - SUMD_W'(corr_q), lim_s);
  end

  // config and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_SPEED_RST;
      search_q <= SEARCH_SPEED_RST;
      prop_q   <= PROP_GAIN_RST;
      deriv_q  <= DERIV_GAIN_RST;
      limit_q  <= DRIVE_LIMIT_RST;
      prev_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE_SPEED:   base_q   <= cfg_wdata_i[SPEED_W-1:0];
          CFG_SEARCH_SPEED: search_q <= cfg_wdata_i[SPEED_W-1:0];
          CFG_PROP_GAIN:    prop_q   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_DERIV_GAIN:   deriv_q  <= cfg_wdata_i[GAIN_W-1:0];
          CFG_DRIVE_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        cnt_q <= DIV_CNT_W'(DIV_W - 1);
      end else if (cmd_i.div_step && (cnt_q != '0)) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
      if (cmd_i.drive) begin
        prev_q <= offset_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_c;
      neg_q     <= sum_c[SUM_W-1];
      dq_q      <= {mag_c, {FRAC_BITS{1'b0}}};
      rem_q     <= '0;
      divisor_q <= count_c;
    end
    if (cmd_i.div_step) begin
      dq_q  <= {dq_q[DIV_W-2:0], qbit_c};
      rem_q <= rem_c;
    end
    if (cmd_i.mul_prop) begin
      offset_q <= offset_c;
      prod_p_q <= prod_c;
    end
    if (cmd_i.mul_deriv) begin
      prod_d_q <= prod_c;
    end
    if (cmd_i.corr) begin
      corr_q <= corr_c;
    end
    if (cmd_i.drive) begin
      left_q  <= DRIVE_W'(lsum_c);
      right_q <= DRIVE_W'(rsum_c);
    end
    if (cmd_i.out_load) begin
      steer_mode_o <= mode_q;
      unique case (mode_q)
        MODE_TRACK: begin
          left_drive_o  <= left_q;
          right_drive_o <= right_q;
          hold_ms_o     <= HOLD_TRACK;
          line_pos_o    <= offset_q;
        end
        MODE_PIVOT_L: begin
          left_drive_o  <= PIVOT_L_LEFT;
          right_drive_o <= PIVOT_L_RIGHT;
          hold_ms_o     <= HOLD_PIVOT_L;
          line_pos_o    <= '0;
        end
        MODE_PIVOT_R: begin
          left_drive_o  <= PIVOT_R_LEFT;
          right_drive_o <= PIVOT_R_RIGHT;
          hold_ms_o     <= HOLD_PIVOT_R;
          line_pos_o    <= '0;
        end
        MODE_LOST: begin
          left_drive_o  <= $signed({{(DRIVE_W-SPEED_W+1){1'b0}}, search_q[SPEED_W-1:1]});
          right_drive_o <= $signed({{(DRIVE_W-SPEED_W+1){1'b0}}, search_q[SPEED_W-1:1]});
          hold_ms_o     <= HOLD_TRACK;
          line_pos_o    <= '0;
        end
        default: begin
          left_drive_o  <= '0;
          right_drive_o <= '0;
          hold_ms_o     <= HOLD_TRACK;
          line_pos_o    <= '0;
        end
      endcase
    end
  end

endmodule

/* test/line_follow_pd_steering_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_pd_steering_test
// self-checking bench for the pd line follower: a scoreboard class predicts
// each wheel command from the sensor sample, the register settings and the
// last tracking offset, and compares every command field with the oldest
// prediction. samples are sent in random bursts while the command side stalls
// on its own pattern, over several register settings including the extremes
// ----------------------------------------------------------------------------
module line_follow_pd_steering_test;
  import lfpd_pkg::*;

  localparam int N_PHASES         = 8;
  localparam int ITEMS_PER_PHASE  = 225;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int HOLD_OFF_AT      = 60;
  localparam int DRAIN_PAUSE_AT   = 140;
  localparam int SETTLE_CYCLES    = 30;
  localparam int CFG_UNUSED_FIRST = 5;

  typedef struct packed {
    logic signed [DRIVE_W-1:0]  left;
    logic signed [DRIVE_W-1:0]  right;
    steer_mode_e                mode;
    logic [HOLD_W-1:0]          hold;
    logic signed [OFFSET_W-1:0] offset;
  } steer_cmd_t;

  class steer_scoreboard;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] seek_speed;
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] drive_limit;
    int                 prev_offs;
    steer_cmd_t         cmd_q[$];
    int n_errors, n_checked, n_track, n_pivot_l, n_pivot_r, n_lost, n_settings;

    function new();
      cruise_speed = BASE_SPEED_RST;
      seek_speed   = SEARCH_SPEED_RST;
      prop_gain    = PROP_GAIN_RST;
      deriv_gain   = DERIV_GAIN_RST;
      drive_limit  = DRIVE_LIMIT_RST;
      prev_offs    = 0;
      n_errors  = 0;
      n_checked = 0;
      n_track   = 0;
      n_pivot_l = 0;
      n_pivot_r = 0;
      n_lost    = 0;
      n_settings = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE_SPEED:   cruise_speed = data[SPEED_W-1:0];
        CFG_SEARCH_SPEED: seek_speed   = data[SPEED_W-1:0];
        CFG_PROP_GAIN:    prop_gain    = data[GAIN_W-1:0];
        CFG_DERIV_GAIN:   deriv_gain   = data[GAIN_W-1:0];
        CFG_DRIVE_LIMIT:  drive_limit  = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SENSOR_COUNT-1:0] bits);
      steer_cmd_t cmd;
      int     sum;
      int     count;
      int     offs;
      longint pd;
      longint corr;
      longint lim;
      longint bs;
      longint pg;
      longint dg;
      longint l;
      longint r;
      sum = 0;
      count = 0;
      cmd.offset = '0;
      if (bits[0]) begin
        cmd.left  = PIVOT_L_LEFT;
        cmd.right = PIVOT_L_RIGHT;
        cmd.mode  = MODE_PIVOT_L;
        cmd.hold  = HOLD_PIVOT_L;
        n_pivot_l++;
      end else if (bits[SENSOR_COUNT-1]) begin
        cmd.left  = PIVOT_R_LEFT;
        cmd.right = PIVOT_R_RIGHT;
        cmd.mode  = MODE_PIVOT_R;
        cmd.hold  = HOLD_PIVOT_R;
        n_pivot_r++;
      end else begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (bits[i]) begin
            sum += WEIGHTS[i];
            count++;
          end
        end
        if (count == 0) begin
          cmd.left  = DRIVE_W'(seek_speed >> 1);
          cmd.right = DRIVE_W'(seek_speed >> 1);
          cmd.mode  = MODE_LOST;
          cmd.hold  = HOLD_TRACK;
          n_lost++;
        end else begin
          offs = (sum * (1 << FRAC_BITS)) / count;
          pg   = prop_gain;
          dg   = deriv_gain;
          lim  = drive_limit;
          bs   = cruise_speed;
          pd   = longint'(offs) * pg + (longint'(offs) - longint'(prev_offs)) * dg;
          corr = pd / (longint'(1) << (FRAC_BITS + GAIN_FRAC));
          l = bs + corr;
          r = bs - corr;
          if (l > lim) l = lim;
          if (l < -lim) l = -lim;
          if (r > lim) r = lim;
          if (r < -lim) r = -lim;
          prev_offs = offs;
          cmd.left   = DRIVE_W'(l);
          cmd.right  = DRIVE_W'(r);
          cmd.mode   = MODE_TRACK;
          cmd.hold   = HOLD_TRACK;
          cmd.offset = OFFSET_W'(offs);
          n_track++;
        end
      end
      cmd_q.push_back(cmd);
    endfunction

    function void check_command(logic signed [DRIVE_W-1:0] left,
                                logic signed [DRIVE_W-1:0] right,
                                logic [MODE_W-1:0] mode,
                                logic [HOLD_W-1:0] hold,
                                logic signed [OFFSET_W-1:0] offset);
      steer_cmd_t exp_cmd;
      if (cmd_q.size() == 0) begin
        $error("command with no sample pending: left %0d right %0d mode %0d",
               left, right, mode);
        n_errors++;
      end else begin
        exp_cmd = cmd_q.pop_front();
        n_checked++;
        if (left !== exp_cmd.left) begin
          $error("left_drive: expected %0d, actual %0d", exp_cmd.left, left);
          n_errors++;
        end
        if (right !== exp_cmd.right) begin
          $error("right_drive: expected %0d, actual %0d", exp_cmd.right, right);
          n_errors++;
        end
        if (mode !== exp_cmd.mode) begin
          $error("steer_mode: expected %0d, actual %0d", exp_cmd.mode, mode);
          n_errors++;
        end
        if (hold !== exp_cmd.hold) begin
          $error("hold_ms: expected %0d, actual %0d", exp_cmd.hold, hold);
          n_errors++;
        end
        if (offset !== exp_cmd.offset) begin
          $error("line_pos: expected %0d, actual %0d", exp_cmd.offset, offset);
          n_errors++;
        end
      end
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_idx_i;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [SENSOR_COUNT-1:0]       sensor_bits_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [DRIVE_W-1:0]     left_drive_o;
  logic signed [DRIVE_W-1:0]     right_drive_o;
  logic [MODE_W-1:0]             steer_mode_o;
  logic [HOLD_W-1:0]             hold_ms_o;
  logic signed [OFFSET_W-1:0]    line_pos_o;

  steer_scoreboard sb;
  int burst_left;
  int hold_reqs;
  int n_sent;

  line_follow_pd_steering i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .steer_mode_o  (steer_mode_o),
    .hold_ms_o     (hold_ms_o),
    .line_pos_o    (line_pos_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_command(left_drive_o, right_drive_o, steer_mode_o, hold_ms_o, line_pos_o);
    end
  end

  // command side: random ready runs, plus a long hold-off on request
  initial begin
    int run_left;
    int hold_left;
    int hold_seen;
    bit rdy;
    run_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    rdy = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rdy = ($urandom_range(0, 2) != 0);
          if (rdy) begin
            run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
          end else begin
            run_left = $urandom_range(1, 12);
          end
        end
        run_left--;
        out_ready_i <= rdy;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] bs, input logic [CFG_DATA_W-1:0] ss,
                          input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] dg,
                          input logic [CFG_DATA_W-1:0] lim);
    write_reg(CFG_BASE_SPEED, bs);
    write_reg(CFG_SEARCH_SPEED, ss);
    write_reg(CFG_PROP_GAIN, pg);
    write_reg(CFG_DERIV_GAIN, dg);
    write_reg(CFG_DRIVE_LIMIT, lim);
    sb.n_settings++;
  endtask

  task automatic send_sample(input logic [SENSOR_COUNT-1:0] bits);
    in_valid_i    <= 1'b1;
    sensor_bits_i <= bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(bits);
    n_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [SENSOR_COUNT-1:0] pick_sample();
    int sel;
    logic [SENSOR_COUNT-1:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      b = {1'b0, 6'($urandom), 1'b0};
    end else if (sel < 80) begin
      b = 8'($urandom) | 8'h01;
    end else if (sel < 88) begin
      b = (8'($urandom) & 8'hFE) | 8'h80;
    end else if (sel < 93) begin
      b = '0;
    end else begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int hi);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic configure(input int ph);
    case (ph)
      1: set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      2: set_regs(16'd500, 16'd500, 16'hFFFF, 16'hFFFF, 16'd1000);
      3: begin
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // writes to unused indexes must change nothing
        for (int k = CFG_UNUSED_FIRST; k < (1 << CFG_IDX_W); k++) begin
          write_reg(CFG_IDX_W'(k), 16'($urandom));
        end
      end
      default: set_regs(pick_reg(500), pick_reg(500), pick_reg(65535), pick_reg(65535),
                        pick_reg(1000));
    endcase
  endtask

  initial begin
    logic [SENSOR_COUNT-1:0] directed[$];
    directed = '{8'h00, 8'h01, 8'h80, 8'h81, 8'hFF, 8'h02, 8'h40, 8'h04, 8'h20, 8'h08,
                 8'h10, 8'h18, 8'h06, 8'h60, 8'h7E, 8'h0E, 8'h70, 8'h22, 8'h42, 8'h7F,
                 8'hFE, 8'h55, 8'hAA, 8'h00, 8'h02};
    sb = new();
    burst_left    = 0;
    hold_reqs     = 0;
    n_sent        = 0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    sensor_bits_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_sample(directed[i]);
    stop_sending();
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) configure(ph);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == HOLD_OFF_AT) hold_reqs++;
        if (i == DRAIN_PAUSE_AT) begin
          stop_sending();
          drain();
        end
        send_sample(pick_sample());
      end
      stop_sending();
      drain();
    end

    $display("%0d samples sent, %0d commands checked under %0d register settings",
             n_sent, sb.n_checked, sb.n_settings);
    $display("tracking %0d, left pivot %0d, right pivot %0d, line lost %0d",
             sb.n_track, sb.n_pivot_l, sb.n_pivot_r, sb.n_lost);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
